FILE: design/u8u16dec_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: result types, queue sizing, byte and code point constants.
// No dependencies; the core, the result queue and the top level refer to it by scoped names.
package u8u16dec_pkg;

    localparam int unsigned MaxRes = 3;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);
    localparam int unsigned CntW   = $clog2(QDepth + 1);
    localparam int unsigned NumW   = $clog2(MaxRes + 1);

    localparam logic        KIND_UNIT   = 1'b0;
    localparam logic        KIND_STATUS = 1'b1;

    localparam logic [7:0]  ByteAsciiLim = 8'h80;
    localparam logic [7:0]  ByteLead2    = 8'hC0;
    localparam logic [7:0]  ByteLead3    = 8'hE0;
    localparam logic [7:0]  ByteLead4    = 8'hF0;
    localparam logic [7:0]  ByteBadLead  = 8'hF8;
    localparam logic [7:0]  ByteBom0     = 8'hEF;
    localparam logic [1:0]  ContTag      = 2'b10;

    localparam logic [20:0] BomCp        = 21'h00FEFF;
    localparam logic [20:0] SuppBase     = 21'h010000;
    localparam logic [20:0] CpLimit      = 21'h110000;
    localparam logic [5:0]  HiSurrTag    = 6'b110110;
    localparam logic [5:0]  LoSurrTag    = 6'b110111;

    localparam logic [15:0] MaxUnitsReset = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [15:0] code_unit;
        logic [15:0] unit_count;
        logic        error;
        logic        has_bom;
        logic        end_of_run;
    } t_result;

    typedef struct packed {
        logic [NumW-1:0]       num;
        t_result [MaxRes-1:0]  res;
    } t_push;

endpackage

FILE: design/u8u16dec_if.sv
// Handshake channels of the UTF-8 to UTF-16 decoder: byte input and result output.
// Depends on nothing but the standard valid/ready convention.
interface u8u16dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8u16dec_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic        error;
    logic        has_bom;
    logic        end_of_run;

    modport source (output valid, output kind, output code_unit, output unit_count,
                    output error, output has_bom, output end_of_run, input ready);
    modport sink   (input valid, input kind, input code_unit, input unit_count,
                    input error, input has_bom, input end_of_run, output ready);
endinterface

FILE: design/u8u16dec_core.sv
// Decode core: stream state registers, capacity register and the per-byte decode logic.
// Produces up to three results per accepted byte; uses u8u16dec_pkg.
module u8u16dec_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_final_byte,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    output u8u16dec_pkg::t_push   o_push
);

    logic [1:0]  r_bytes_left, n_bytes_left;
    logic [20:0] r_cp, n_cp;
    logic [15:0] r_units, n_units;
    logic        r_at_start, n_at_start;
    logic        r_bom_cand, n_bom_cand;
    logic        r_seen_bom, n_seen_bom;
    logic        r_err, n_err;
    logic [15:0] r_max_units;

    logic        done;
    logic        fail;
    logic        emit1;
    logic        emit2;
    logic [20:0] supp_off;
    logic [1:0]  nu;
    logic [1:0]  num;
    logic [15:0] st_units;
    logic        st_err;
    logic        st_bom;
    u8u16dec_pkg::t_result [u8u16dec_pkg::MaxRes-1:0] res;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_cp         = r_cp;
        n_units      = r_units;
        n_bom_cand   = r_bom_cand;
        n_seen_bom   = r_seen_bom;
        n_err        = r_err;
        n_at_start   = 1'b0;
        done         = 1'b0;
        fail         = 1'b0;
        emit1        = 1'b0;
        emit2        = 1'b0;

        if (!r_err) begin
            if (r_bytes_left == 2'd0) begin
                priority if (i_data_byte < u8u16dec_pkg::ByteAsciiLim) begin
                    n_cp = {13'd0, i_data_byte};
                    done = 1'b1;
                end else if (i_data_byte < u8u16dec_pkg::ByteLead2) begin
                    fail = 1'b1;
                end else if (i_data_byte < u8u16dec_pkg::ByteLead3) begin
                    n_cp         = {16'd0, i_data_byte[4:0]};
                    n_bytes_left = 2'd1;
                end else if (i_data_byte < u8u16dec_pkg::ByteLead4) begin
                    n_cp         = {17'd0, i_data_byte[3:0]};
                    n_bytes_left = 2'd2;
                    n_bom_cand   = r_at_start && (i_data_byte == u8u16dec_pkg::ByteBom0);
                end else if (i_data_byte < u8u16dec_pkg::ByteBadLead) begin
                    n_cp         = {18'd0, i_data_byte[2:0]};
                    n_bytes_left = 2'd3;
                end else begin
                    fail = 1'b1;
                end
            end else if (i_data_byte[7:6] != u8u16dec_pkg::ContTag) begin
                fail = 1'b1;
            end else begin
                n_cp         = {r_cp[14:0], i_data_byte[5:0]};
                n_bytes_left = r_bytes_left - 2'd1;
                done         = (r_bytes_left == 2'd1);
            end

            if (done) begin
                priority if (r_bom_cand && n_cp == u8u16dec_pkg::BomCp) begin
                    n_seen_bom = 1'b1;
                end else if (n_cp < u8u16dec_pkg::SuppBase) begin
                    if (r_units >= r_max_units) begin
                        fail = 1'b1;
                    end else begin
                        emit1 = 1'b1;
                    end
                end else if (n_cp < u8u16dec_pkg::CpLimit) begin
                    if (({1'b0, r_units} + 17'd1) >= {1'b0, r_max_units}) begin
                        fail = 1'b1;
                    end else begin
                        emit2 = 1'b1;
                    end
                end else begin
                    fail = 1'b1;
                end
                n_bom_cand = 1'b0;
            end
        end

        // truncated stream
        if (i_final_byte && n_bytes_left != 2'd0) begin
            fail = 1'b1;
        end
        if (fail) begin
            n_err        = 1'b1;
            n_bytes_left = 2'd0;
            n_bom_cand   = 1'b0;
        end

        supp_off = n_cp - u8u16dec_pkg::SuppBase;
        nu       = emit2 ? 2'd2 : (emit1 ? 2'd1 : 2'd0);
        n_units  = r_units + {14'd0, nu};
        st_units = n_units;
        st_err   = n_err;
        st_bom   = n_seen_bom;
        num      = nu + {1'b0, i_final_byte};

        res = '0;
        if (emit1) begin
            res[0].kind      = u8u16dec_pkg::KIND_UNIT;
            res[0].code_unit = n_cp[15:0];
        end
        if (emit2) begin
            res[0].kind      = u8u16dec_pkg::KIND_UNIT;
            res[0].code_unit = {u8u16dec_pkg::HiSurrTag, supp_off[19:10]};
            res[1].kind      = u8u16dec_pkg::KIND_UNIT;
            res[1].code_unit = {u8u16dec_pkg::LoSurrTag, supp_off[9:0]};
        end
        if (i_final_byte) begin
            res[nu].kind       = u8u16dec_pkg::KIND_STATUS;
            res[nu].unit_count = st_units;
            res[nu].error      = st_err;
            res[nu].has_bom    = st_bom;
        end
        if (num != 2'd0) begin
            res[num - 2'd1].end_of_run = 1'b1;
        end

        // clear stream state after the final byte
        if (i_final_byte) begin
            n_bytes_left = 2'd0;
            n_cp         = '0;
            n_units      = '0;
            n_at_start   = 1'b1;
            n_bom_cand   = 1'b0;
            n_seen_bom   = 1'b0;
            n_err        = 1'b0;
        end
    end

    assign o_push.num = i_acc ? num : 2'd0;
    assign o_push.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 2'd0;
            r_cp         <= '0;
            r_units      <= '0;
            r_at_start   <= 1'b1;
            r_bom_cand   <= 1'b0;
            r_seen_bom   <= 1'b0;
            r_err        <= 1'b0;
            r_max_units  <= u8u16dec_pkg::MaxUnitsReset;
        end else begin
            if (i_acc) begin
                r_bytes_left <= n_bytes_left;
                r_cp         <= n_cp;
                r_units      <= n_units;
                r_at_start   <= n_at_start;
                r_bom_cand   <= n_bom_cand;
                r_seen_bom   <= n_seen_bom;
                r_err        <= n_err;
            end
            if (i_cfg_we) begin
                r_max_units <= i_cfg_wdata;
            end
        end
    end

    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_final_byte |=> r_at_start && r_units == 16'd0 && !r_err && !r_seen_bom)
        else $error("stream state not cleared after final item");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_bytes_left == 2'd0 && !r_bom_cand)
        else $error("sequence left open after error");

    a_bom_cand_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bom_cand |-> r_bytes_left != 2'd0)
        else $error("BOM candidate without open sequence");

endmodule

FILE: design/u8u16dec_outq.sv
// Result queue: four-entry register queue that takes up to three results per item
// and returns one per cycle while the output channel is ready; uses u8u16dec_pkg and u8u16dec_out_if.
module u8u16dec_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8u16dec_pkg::t_push  i_push,
    output logic                 o_space,
    u8u16dec_out_if.source       o_res
);

    logic [u8u16dec_pkg::QAw-1:0]  r_rd;
    logic [u8u16dec_pkg::QAw-1:0]  r_wr;
    logic [u8u16dec_pkg::CntW-1:0] r_count;
    logic [u8u16dec_pkg::CntW-1:0] n_count;
    u8u16dec_pkg::t_result         r_ent [u8u16dec_pkg::QDepth];
    u8u16dec_pkg::t_result         head;
    logic                          pop;

    assign head     = r_ent[r_rd];
    assign pop      = o_res.valid && o_res.ready;
    assign o_space  = r_count <= u8u16dec_pkg::CntW'(u8u16dec_pkg::QDepth - u8u16dec_pkg::MaxRes);
    assign n_count  = r_count + u8u16dec_pkg::CntW'(i_push.num) - u8u16dec_pkg::CntW'(pop);

    assign o_res.valid      = r_count != '0;
    assign o_res.kind       = head.kind;
    assign o_res.code_unit  = head.code_unit;
    assign o_res.unit_count = head.unit_count;
    assign o_res.error      = head.error;
    assign o_res.has_bom    = head.has_bom;
    assign o_res.end_of_run = head.end_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (pop) begin
                r_rd <= r_rd + u8u16dec_pkg::QAw'(1);
            end
            r_wr    <= r_wr + u8u16dec_pkg::QAw'(i_push.num);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < u8u16dec_pkg::MaxRes; k++) begin
            if (k < int'(i_push.num)) begin
                r_ent[r_wr + u8u16dec_pkg::QAw'(k)] <= i_push.res[k];
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= u8u16dec_pkg::CntW'(u8u16dec_pkg::QDepth))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != '0 |-> o_space)
        else $error("results pushed without room");

    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != '0 && !pop |=> o_res.valid)
        else $error("pushed result not presented");

endmodule

FILE: design/utf8_to_utf16_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 decoder: decode core feeding a result queue.
// Depends on u8u16dec_pkg, u8u16dec_if, u8u16dec_core and u8u16dec_outq.
//
//  port       dir  carries
//  i_in       in   UTF-8 byte with last-byte flag, valid/ready
//  o_res      out  UTF-16 unit or end-of-stream status, valid/ready
//  i_cfg_*    in   write of max_units, no handshake
//
// One byte is accepted per cycle while at most one result is queued; each byte
// yields zero to three results, delivered one per cycle from the four-entry queue while o_res is ready.
// A byte with a surrogate pair and the final flag yields three results and holds input until at most one is queued.
// Output stalls back up into the queue; no item is dropped.
// Synchronous active-low reset clears stream state and sets max_units to 65535.
module utf8_to_utf16_decoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u8u16dec_in_if.sink     i_in,
    u8u16dec_out_if.source  o_res,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata
);

    u8u16dec_pkg::t_push push;
    logic                space;
    logic                acc;

    assign i_in.ready = space;
    assign acc        = i_in.valid && space;

    u8u16dec_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (push)
    );

    u8u16dec_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_res   (o_res)
    );

endmodule

FILE: tb/sv/u8u16dec_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the UTF-8 to UTF-16 decoder: watches the byte and result channels,
// predicts the UTF-16 units and stream status of every accepted byte and compares them.
// Depends on u8u16dec_pkg and the u8u16dec_in_if / u8u16dec_out_if interfaces.
module u8u16dec_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16dec_in_if      in_ch,
    u8u16dec_out_if     res_ch,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_pending
);

    localparam int ReportLimit = 10;

    logic [1:0]  seq_left;
    logic [20:0] cp_acc;
    logic [15:0] units_emitted;
    logic        first_byte;
    logic        bom_lead;
    logic        bom_dropped;
    logic        stream_failed;
    logic [15:0] unit_cap;

    u8u16dec_pkg::t_result expected_results[$];
    u8u16dec_pkg::t_result got;
    u8u16dec_pkg::t_result want;

    task automatic clear_stream();
        seq_left      = '0;
        cp_acc        = '0;
        units_emitted = '0;
        first_byte    = 1'b1;
        bom_lead      = 1'b0;
        bom_dropped   = 1'b0;
        stream_failed = 1'b0;
    endtask

    task automatic mark_failed();
        stream_failed = 1'b1;
        seq_left      = '0;
        bom_lead      = 1'b0;
    endtask

    task automatic push_unit(input logic [15:0] unit);
        u8u16dec_pkg::t_result r;
        r           = '0;
        r.kind      = u8u16dec_pkg::KIND_UNIT;
        r.code_unit = unit;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        int                    produced;
        logic                  done;
        logic [20:0]           supp;
        u8u16dec_pkg::t_result r;
        produced = 0;
        done     = 1'b0;
        if (!stream_failed) begin
            if (seq_left == 0) begin
                if (b < u8u16dec_pkg::ByteAsciiLim) begin
                    cp_acc = {13'b0, b};
                    done   = 1'b1;
                end else if (b < u8u16dec_pkg::ByteLead2) begin
                    mark_failed();
                end else if (b < u8u16dec_pkg::ByteLead3) begin
                    cp_acc   = {16'b0, b[4:0]};
                    seq_left = 2'd1;
                end else if (b < u8u16dec_pkg::ByteLead4) begin
                    cp_acc   = {17'b0, b[3:0]};
                    seq_left = 2'd2;
                    bom_lead = first_byte && (b == u8u16dec_pkg::ByteBom0);
                end else if (b < u8u16dec_pkg::ByteBadLead) begin
                    cp_acc   = {18'b0, b[2:0]};
                    seq_left = 2'd3;
                end else begin
                    mark_failed();
                end
            end else if (b[7:6] != u8u16dec_pkg::ContTag) begin
                mark_failed();
            end else begin
                cp_acc   = {cp_acc[14:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 0) done = 1'b1;
            end

            if (done) begin
                if (bom_lead && cp_acc == u8u16dec_pkg::BomCp) begin
                    bom_dropped = 1'b1;
                end else if (cp_acc < u8u16dec_pkg::SuppBase) begin
                    if (units_emitted >= unit_cap) begin
                        mark_failed();
                    end else begin
                        push_unit(cp_acc[15:0]);
                        produced++;
                        units_emitted = units_emitted + 16'd1;
                    end
                end else if (cp_acc < u8u16dec_pkg::CpLimit) begin
                    if ({1'b0, units_emitted} + 17'd1 >= {1'b0, unit_cap}) begin
                        mark_failed();
                    end else begin
                        supp = cp_acc - u8u16dec_pkg::SuppBase;
                        push_unit({u8u16dec_pkg::HiSurrTag, supp[19:10]});
                        push_unit({u8u16dec_pkg::LoSurrTag, supp[9:0]});
                        produced += 2;
                        units_emitted = units_emitted + 16'd2;
                    end
                end else begin
                    mark_failed();
                end
                bom_lead = 1'b0;
            end
        end
        first_byte = 1'b0;

        if (fin) begin
            if (seq_left != 0) mark_failed();
            r            = '0;
            r.kind       = u8u16dec_pkg::KIND_STATUS;
            r.unit_count = units_emitted;
            r.error      = stream_failed;
            r.has_bom    = bom_dropped;
            expected_results.insert(expected_results.size(), r);
            produced++;
            clear_stream();
        end

        if (produced > 0) expected_results[expected_results.size() - 1].end_of_run = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stream();
            unit_cap = u8u16dec_pkg::MaxUnitsReset;
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.final_byte);

            if (res_ch.valid && res_ch.ready) begin
                got.kind       = res_ch.kind;
                got.code_unit  = res_ch.code_unit;
                got.unit_count = res_ch.unit_count;
                got.error      = res_ch.error;
                got.has_bom    = res_ch.has_bom;
                got.end_of_run = res_ch.end_of_run;
                if (expected_results.size() == 0) begin
                    if (o_mismatches < ReportLimit)
                        $display("%0t unexpected result: kind=%0d unit=%h count=%0d %s%0d %s%0d %s%0d",
                                 $time, got.kind, got.code_unit, got.unit_count,
                                 "err=", got.error, "bom=", got.has_bom,
                                 "eor=", got.end_of_run);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.code_unit !== want.code_unit ||
                        got.unit_count !== want.unit_count || got.error !== want.error ||
                        got.has_bom !== want.has_bom || got.end_of_run !== want.end_of_run) begin
                        if (o_mismatches < ReportLimit) begin
                            $display("%0t mismatch, expected: kind=%0d unit=%h count=%0d",
                                     $time, want.kind, want.code_unit, want.unit_count,
                                     "  err=%0d bom=%0d eor=%0d",
                                     want.error, want.has_bom, want.end_of_run);
                            $display("%0t mismatch, actual:   kind=%0d unit=%h count=%0d",
                                     $time, got.kind, got.code_unit, got.unit_count,
                                     "  err=%0d bom=%0d eor=%0d",
                                     got.error, got.has_bom, got.end_of_run);
                        end
                        o_mismatches++;
                    end
                end
            end

            if (i_cfg_we) unit_cap = i_cfg_wdata;
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/sv/utf8_to_utf16_decoder_unit_tb.sv
`timescale 1ns / 100ps
// Top of the UTF-8 to UTF-16 decoder testbench: clock, reset, byte streams, capacity writes
// and random stalls on both channels; u8u16dec_result_checker does the prediction.
// Depends on u8u16dec_pkg, the decoder interfaces and utf8_to_utf16_decoder_unit.
module utf8_to_utf16_decoder_unit_tb;

    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 20;
    localparam int PhaseBytes   = 18;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_fire;
    bit          send_idle;
    bit          recv_idle;
    int          mismatches;
    int          pending;
    int          cycles;
    int          stall_left;
    int          phase_bytes;

    u8u16dec_in_if  in_ch ();
    u8u16dec_out_if res_ch ();

    utf8_to_utf16_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    u8u16dec_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .res_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
        cycles  <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (recv_idle && $urandom_range(0, 3) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (send_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= fin;
        do @(negedge i_clk); while (!in_fire);
        phase_bytes++;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
    endtask

    // hold the input idle until the decoder has drained, then write the capacity
    task automatic set_capacity(input logic [15:0] cap);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        phase_bytes = 0;
    endtask

    // well-formed characters with random content, some noise, corruption and truncation
    task automatic send_stream(input int n_chars);
        logic [7:0] seq[$];
        int         r;
        int         pos;
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0) seq = {8'hEF, 8'hBB, 8'hBF};
        for (int i = 0; i < n_chars; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                seq.insert(seq.size(), 8'($urandom_range(0, 127)));
            end else if (r < 45) begin
                seq.insert(seq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
            end else if (r < 62) begin
                seq.insert(seq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
            end else if (r < 67) begin
                seq.insert(seq.size(), 8'hEF);
                seq.insert(seq.size(), 8'hBB);
                seq.insert(seq.size(), 8'hBF);
            end else if (r < 84) begin
                seq.insert(seq.size(), 8'hF0 | 8'(($urandom_range(0, 7) == 0) ?
                                       $urandom_range(4, 7) : $urandom_range(0, 3)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
                seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
            end else begin
                seq.insert(seq.size(), 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, seq.size() - 1);
            seq[pos] = 8'($urandom_range(0, 255));
        end
        if (seq.size() > 1 && $urandom_range(0, 11) == 0) void'(seq.pop_back());
        send_bytes(seq);
    endtask

    task automatic run_phase(input logic [15:0] cap);
        set_capacity(cap);
        while (phase_bytes < PhaseBytes)
            send_stream(($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        res_ch.ready     = 1'b0;
        in_fire          = 1'b0;
        send_idle        = 1'b0;
        recv_idle        = 1'b0;
        stall_left       = 0;
        cycles           = 0;
        phase_bytes      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_capacity(u8u16dec_pkg::MaxUnitsReset);
        send_bytes({8'hEF, 8'hBB, 8'hBF, 8'h7F});
        send_bytes({8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80});
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_bytes({8'h80, 8'h41});
        send_bytes({8'hFF});
        send_bytes({8'hE2, 8'h41});
        send_bytes({8'hF7, 8'hBF, 8'hBF, 8'hBF});
        send_bytes({8'hC3});
        send_bytes({8'h00});

        run_phase(16'd0);
        run_phase(16'd1);
        run_phase(16'd2);
        run_phase(16'd3);
        run_phase(16'($urandom_range(4, 12)));
        run_phase(16'($urandom_range(0, 65535)));
        run_phase(16'hFFFF);

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
